>>> rtl/itvdft_pkg.sv
// ----------------------------------------------------------------------------
// itvdft_pkg
// Shared types, constants and tables for the image to visibility dft unit.
// ----------------------------------------------------------------------------
package itvdft_pkg;

   // image and channel limits
   localparam int MAX_RA_CELLS  = 64;
   localparam int MAX_DEC_CELLS = 64;
   localparam int MAX_CHANNELS  = 64;
   localparam int PIX_DEPTH     = MAX_RA_CELLS * MAX_DEC_CELLS;
   localparam int PIX_AW        = 12;
   localparam int CH_AW         = 6;
   localparam int CNT_W         = 7;

   // speed of light in m/s, the delay divisor
   localparam logic [28:0] LIGHT_MPS = 29'd299792458;

   // cordic
   localparam int CORDIC_STEPS = 16;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // accumulator limits
   localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
   localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;

   typedef enum logic [1:0] {
      OP_LOAD_PIXEL = 2'd0,
      OP_LOAD_FREQ  = 2'd1,
      OP_BASELINE   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CSR_RA_START   = 3'd0,
      CSR_RA_STEP    = 3'd1,
      CSR_RA_CELLS   = 3'd2,
      CSR_DEC_START  = 3'd3,
      CSR_DEC_STEP   = 3'd4,
      CSR_DEC_CELLS  = 3'd5,
      CSR_CHAN_COUNT = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_RR,
      ST_PIX_DD,
      ST_PIX_SQ,
      ST_PIX_UVW,
      ST_PIX_MV,
      ST_PIX_MW,
      ST_PIX_MD,
      ST_PIX_DIV,
      ST_CH_RD,
      ST_CH_M1,
      ST_CH_M2,
      ST_CH_M3,
      ST_CH_DIV,
      ST_CH_COR,
      ST_CH_T1,
      ST_CH_T2,
      ST_OUT_RD,
      ST_OUT_EM
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [11:0]        index;
      logic signed [31:0] flux;
      logic [23:0]        freq_khz;
      logic signed [31:0] u_mm;
      logic signed [31:0] v_mm;
      logic signed [31:0] w_mm;
   } req_type;

   typedef struct packed {
      logic [5:0]         channel;
      logic signed [47:0] vis_real;
      logic signed [47:0] vis_imag;
      logic               last;
   } rsp_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [29:0] atan_turn(input logic [3:0] i);
      logic [29:0] a;
      unique case (i)
         4'd0:  a = 30'd536870912;
         4'd1:  a = 30'd316933406;
         4'd2:  a = 30'd167458907;
         4'd3:  a = 30'd85004756;
         4'd4:  a = 30'd42667331;
         4'd5:  a = 30'd21354465;
         4'd6:  a = 30'd10679838;
         4'd7:  a = 30'd5340245;
         4'd8:  a = 30'd2670163;
         4'd9:  a = 30'd1335087;
         4'd10: a = 30'd667544;
         4'd11: a = 30'd333772;
         4'd12: a = 30'd166886;
         4'd13: a = 30'd83443;
         4'd14: a = 30'd41722;
         default: a = 30'd20861;
      endcase
      return a;
   endfunction

   // count register clamped to its maximum
   function automatic logic [6:0] clamp_cells(input logic [6:0] cnt, input logic [6:0] lim);
      return (cnt > lim) ? lim : cnt;
   endfunction

   // clamp a widened sum to the 48-bit range
   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [49:0] c;
      if (v > ACC_MAX) begin
         c = ACC_MAX;
      end else if (v < ACC_MIN) begin
         c = ACC_MIN;
      end else begin
         c = v;
      end
      return c[47:0];
   endfunction

endpackage

>>> rtl/itvdft_div.sv
// ----------------------------------------------------------------------------
// itvdft_div
// Long division of a 64-bit unsigned value by the speed of light constant,
// four quotient bits per cycle, low 32 quotient bits and the remainder kept.
// ----------------------------------------------------------------------------
module itvdft_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   output logic        done,
   output logic [31:0] quotient,
   output logic [28:0] remainder
);

   logic [63:0] dvd_ff, dvd_in;
   logic [28:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;

   // four restoring steps per cycle
   always_comb begin
      logic [29:0] t;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      for (int j = 0; j < 4; j++) begin
         t = {rem_in, dvd_in[63]};
         dvd_in = {dvd_in[62:0], 1'b0};
         if (t >= {1'b0, itvdft_pkg::LIGHT_MPS}) begin
            rem_in = 29'(t - {1'b0, itvdft_pkg::LIGHT_MPS});
            quo_in = {quo_in[30:0], 1'b1};
         end else begin
            rem_in = t[28:0];
            quo_in = {quo_in[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == 4'd15);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            dvd_ff <= dividend;
            rem_ff <= '0;
            quo_ff <= '0;
         end else if (run_ff) begin
            dvd_ff <= dvd_in;
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/itvdft_sqrt.sv
// ----------------------------------------------------------------------------
// itvdft_sqrt
// Bit-serial integer square root of a value up to 2^60, one root bit a cycle.
// ----------------------------------------------------------------------------
module itvdft_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [60:0] value,
   output logic        done,
   output logic [30:0] root
);

   logic [60:0] v_ff;
   logic [61:0] res_ff;
   logic [60:0] bit_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [61:0] trial;

   assign trial = res_ff + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == 5'd30);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            v_ff   <= value;
            res_ff <= '0;
            bit_ff <= 61'h1 << 60;
         end else if (run_ff) begin
            // one trial subtract per cycle
            if ({1'b0, v_ff} >= trial) begin
               v_ff   <= 61'({1'b0, v_ff} - trial);
               res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[30:0];

endmodule

>>> rtl/itvdft_cordic.sv
// ----------------------------------------------------------------------------
// itvdft_cordic
// Iterative cordic: cosine and sine of a 32-bit phase in turns, one
// rotation a cycle, quadrant folded in at the end.
// ----------------------------------------------------------------------------
module itvdft_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        phase,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);

   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [33:0] x_in, y_in, z_in;
   logic signed [33:0] cs_ff, sn_ff;
   logic [1:0]         quad_ff;
   logic [3:0]         cnt_ff;
   logic               run_ff;
   logic               done_ff;

   // one micro-rotation
   always_comb begin
      logic signed [33:0] xs, ys, at;
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = $signed({4'b0, itvdft_pkg::atan_turn(cnt_ff)});
      if (z_ff >= 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff
                    && (cnt_ff == 4'(itvdft_pkg::CORDIC_STEPS - 1));
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            x_ff    <= itvdft_pkg::CORDIC_GAIN;
            y_ff    <= '0;
            z_ff    <= $signed({4'b0, phase[29:0]});
            quad_ff <= phase[31:30];
         end else if (run_ff) begin
            x_ff   <= x_in;
            y_ff   <= y_in;
            z_ff   <= z_in;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(itvdft_pkg::CORDIC_STEPS - 1)) begin
               run_ff <= 1'b0;
               // quadrant map
               unique case (quad_ff)
                  2'd0: begin cs_ff <= x_in;  sn_ff <= y_in;  end
                  2'd1: begin cs_ff <= -y_in; sn_ff <= x_in;  end
                  2'd2: begin cs_ff <= -x_in; sn_ff <= -y_in; end
                  default: begin cs_ff <= y_in; sn_ff <= -x_in; end
               endcase
            end
         end
      end
   end

   assign done    = done_ff;
   assign cos_out = cs_ff;
   assign sin_out = sn_ff;

endmodule

>>> rtl/image_to_visibility_dft_unit.sv
// ----------------------------------------------------------------------------
// image_to_visibility_dft_unit
// Direct Fourier transform visibility predictor: pixel store, frequency
// table and accumulator memory around one sequencer and shared units.
//
//   channel   ports                                  direction
//   request   start, busy, req_item                  in (busy out)
//   result    rsp_valid, rsp_item                    out
//   control   csr_we, csr_addr, csr_wdata            in
//
// Loads finish in the cycle they are taken; busy stays low.
// For a baseline, per pixel-channel term the constant divider and the cordic
// set the pace, per pixel the square root (skipped below the horizon) and the
// delay divide.
// Accumulators need no clearing pass: the first pixel writes them fresh.
// Each result beat follows its own accumulator read; the receiver cannot stall.
// Reset is synchronous; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module image_to_visibility_dft_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  itvdft_pkg::req_type   req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output itvdft_pkg::rsp_type   rsp_item,
   input  logic                  csr_we,
   input  logic [2:0]            csr_addr,
   input  logic [31:0]           csr_wdata
);

   // configuration registers
   logic [31:0] ra_start_ff, ra_step_ff, dec_start_ff, dec_step_ff;
   logic [6:0]  ra_cells_ff, dec_cells_ff, chan_count_ff;
   logic [6:0]  cols, rows, chans;

   // sequencer state
   itvdft_pkg::state_type state_ff, state_in;
   logic [31:0]        ra_ff, ra_in, dec_ff, dec_in;
   logic [6:0]         col_ff, col_in, row_ff, row_in;
   logic [11:0]        addr_ff, addr_in;
   logic [5:0]         k_ff, k_in;
   logic signed [31:0] u_ff, u_in, v_ff, v_in, w_ff, w_in;
   logic signed [31:0] flux_ff, flux_in;
   logic [63:0]        r2_ff, r2_in;
   logic [30:0]        n_ff, n_in;
   logic signed [63:0] d_ff, d_in;
   logic               neg_ff, neg_in;
   logic [31:0]        dq_ff, dq_in;
   logic [28:0]        dr_ff, dr_in;
   logic [27:0]        f16_ff, f16_in;
   logic [31:0]        pa_ff, pa_in;
   logic signed [49:0] tr_ff, tr_in;
   logic               first_ff, first_in;
   logic               nopix_ff, nopix_in;

   // shared multiplier
   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] prod_ff;
   logic signed [69:0] prod_sh2, prod_sh30;

   // memories
   logic [31:0] pix_mem [itvdft_pkg::PIX_DEPTH];
   logic [23:0] freq_mem [itvdft_pkg::MAX_CHANNELS];
   logic [95:0] acc_mem [itvdft_pkg::MAX_CHANNELS];
   logic [31:0] pix_rdata_ff;
   logic [23:0] freq_rdata_ff;
   logic [95:0] acc_rdata_ff;
   logic        pix_we, freq_we, acc_we;
   logic [95:0] acc_wdata;

   // unit handshakes
   logic        div_start, div_done;
   logic [63:0] div_dividend;
   logic [31:0] div_q;
   logic [28:0] div_r;
   logic        sqrt_start, sqrt_done;
   logic [60:0] sqrt_value;
   logic [30:0] sqrt_root;
   logic        cor_start, cor_done;
   logic [31:0] cor_phase;
   logic signed [33:0] cor_cos, cor_sin;

   logic accept;

   assign cols  = itvdft_pkg::clamp_cells(ra_cells_ff, 7'(itvdft_pkg::MAX_RA_CELLS));
   assign rows  = itvdft_pkg::clamp_cells(dec_cells_ff, 7'(itvdft_pkg::MAX_DEC_CELLS));
   assign chans = itvdft_pkg::clamp_cells(chan_count_ff, 7'(itvdft_pkg::MAX_CHANNELS));

   assign busy   = (state_ff != itvdft_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign prod_sh2  = prod_ff >>> 2;
   assign prod_sh30 = prod_ff >>> 30;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ra_start_ff   <= '0;
         ra_step_ff    <= '0;
         ra_cells_ff   <= 7'(itvdft_pkg::MAX_RA_CELLS);
         dec_start_ff  <= '0;
         dec_step_ff   <= '0;
         dec_cells_ff  <= 7'(itvdft_pkg::MAX_DEC_CELLS);
         chan_count_ff <= 7'(itvdft_pkg::MAX_CHANNELS);
      end else if (csr_we) begin
         unique case (csr_addr)
            itvdft_pkg::CSR_RA_START:   ra_start_ff   <= csr_wdata;
            itvdft_pkg::CSR_RA_STEP:    ra_step_ff    <= csr_wdata;
            itvdft_pkg::CSR_RA_CELLS:   ra_cells_ff   <= csr_wdata[6:0];
            itvdft_pkg::CSR_DEC_START:  dec_start_ff  <= csr_wdata;
            itvdft_pkg::CSR_DEC_STEP:   dec_step_ff   <= csr_wdata;
            itvdft_pkg::CSR_DEC_CELLS:  dec_cells_ff  <= csr_wdata[6:0];
            itvdft_pkg::CSR_CHAN_COUNT: chan_count_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // pixel store and frequency table
   assign pix_we  = accept && (req_item.operation == itvdft_pkg::OP_LOAD_PIXEL);
   assign freq_we = accept && (req_item.operation == itvdft_pkg::OP_LOAD_FREQ)
                    && (req_item.index[11:6] == 6'd0);

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[req_item.index] <= req_item.flux;
      end
      pix_rdata_ff <= pix_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (freq_we) begin
         freq_mem[req_item.index[5:0]] <= req_item.freq_khz;
      end
      freq_rdata_ff <= freq_mem[k_ff];
   end

   // accumulator memory, real in the upper half
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[k_ff] <= acc_wdata;
      end
      acc_rdata_ff <= acc_mem[k_ff];
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         itvdft_pkg::ST_PIX_RD: begin
            mul_a = 35'($signed(ra_ff));
            mul_b = 35'($signed(ra_ff));
         end
         itvdft_pkg::ST_PIX_RR: begin
            mul_a = 35'($signed(dec_ff));
            mul_b = 35'($signed(dec_ff));
         end
         itvdft_pkg::ST_PIX_UVW: begin
            mul_a = 35'($signed(ra_ff));
            mul_b = 35'(u_ff);
         end
         itvdft_pkg::ST_PIX_MV: begin
            mul_a = 35'($signed(dec_ff));
            mul_b = 35'(v_ff);
         end
         itvdft_pkg::ST_PIX_MW: begin
            mul_a = $signed({4'b0, n_ff});
            mul_b = 35'(w_ff);
         end
         itvdft_pkg::ST_CH_M1: begin
            mul_a = $signed({3'b0, dq_ff});
            mul_b = $signed({7'b0, freq_rdata_ff, 4'b0});
         end
         itvdft_pkg::ST_CH_M2: begin
            mul_a = $signed({6'b0, dr_ff});
            mul_b = $signed({7'b0, f16_ff});
         end
         itvdft_pkg::ST_CH_COR: begin
            mul_a = 35'(flux_ff);
            mul_b = 35'(cor_cos);
         end
         itvdft_pkg::ST_CH_T1: begin
            mul_a = 35'(flux_ff);
            mul_b = 35'(cor_sin);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer next state and datapath
   always_comb begin
      logic [63:0]        r2_sum;
      logic signed [63:0] d_sum;
      logic signed [49:0] ti;
      logic signed [47:0] base_r, base_i;
      logic [6:0]         k_next;

      state_in = state_ff;
      ra_in    = ra_ff;
      dec_in   = dec_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      addr_in  = addr_ff;
      k_in     = k_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      flux_in  = flux_ff;
      r2_in    = r2_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      f16_in   = f16_ff;
      pa_in    = pa_ff;
      tr_in    = tr_ff;
      first_in = first_ff;
      nopix_in = nopix_ff;

      div_start    = 1'b0;
      div_dividend = '0;
      sqrt_start   = 1'b0;
      sqrt_value   = '0;
      cor_start    = 1'b0;
      cor_phase    = pa_ff + div_q;
      acc_we       = 1'b0;
      acc_wdata    = '0;
      rsp_valid    = 1'b0;

      r2_sum = r2_ff + 64'(prod_ff);
      d_sum  = d_ff + prod_sh2[63:0];
      ti     = prod_sh30[49:0];
      base_r = first_ff ? 48'sd0 : $signed(acc_rdata_ff[95:48]);
      base_i = first_ff ? 48'sd0 : $signed(acc_rdata_ff[47:0]);
      k_next = {1'b0, k_ff} + 7'd1;

      rsp_item.channel  = k_ff;
      rsp_item.vis_real = nopix_ff ? 48'sd0 : $signed(acc_rdata_ff[95:48]);
      rsp_item.vis_imag = nopix_ff ? 48'sd0 : $signed(acc_rdata_ff[47:0]);
      rsp_item.last     = (k_next == chans);

      unique case (state_ff)
         itvdft_pkg::ST_IDLE: begin
            // baseline start
            if (accept && (req_item.operation == itvdft_pkg::OP_BASELINE)
                && (chans != 7'd0)) begin
               u_in     = req_item.u_mm;
               v_in     = req_item.v_mm;
               w_in     = req_item.w_mm;
               ra_in    = ra_start_ff;
               dec_in   = dec_start_ff;
               col_in   = '0;
               row_in   = '0;
               addr_in  = '0;
               k_in     = '0;
               first_in = 1'b1;
               if ((rows == 7'd0) || (cols == 7'd0)) begin
                  nopix_in = 1'b1;
                  state_in = itvdft_pkg::ST_OUT_RD;
               end else begin
                  nopix_in = 1'b0;
                  state_in = itvdft_pkg::ST_PIX_RD;
               end
            end
         end
         itvdft_pkg::ST_PIX_RD: state_in = itvdft_pkg::ST_PIX_RR;
         itvdft_pkg::ST_PIX_RR: begin
            r2_in    = 64'(prod_ff);
            flux_in  = $signed(pix_rdata_ff);
            state_in = itvdft_pkg::ST_PIX_DD;
         end
         itvdft_pkg::ST_PIX_DD: begin
            // below the horizon n is zero
            if (r2_sum >= (64'h1 << 60)) begin
               n_in     = '0;
               state_in = itvdft_pkg::ST_PIX_UVW;
            end else begin
               sqrt_start = 1'b1;
               sqrt_value = 61'((64'h1 << 60) - r2_sum);
               state_in   = itvdft_pkg::ST_PIX_SQ;
            end
         end
         itvdft_pkg::ST_PIX_SQ: begin
            if (sqrt_done) begin
               n_in     = sqrt_root;
               state_in = itvdft_pkg::ST_PIX_UVW;
            end
         end
         itvdft_pkg::ST_PIX_UVW: state_in = itvdft_pkg::ST_PIX_MV;
         itvdft_pkg::ST_PIX_MV: begin
            d_in     = prod_sh2[63:0];
            state_in = itvdft_pkg::ST_PIX_MW;
         end
         itvdft_pkg::ST_PIX_MW: begin
            d_in     = d_sum;
            state_in = itvdft_pkg::ST_PIX_MD;
         end
         itvdft_pkg::ST_PIX_MD: begin
            // divide the delay magnitude by c
            neg_in       = d_sum[63];
            div_start    = 1'b1;
            div_dividend = d_sum[63] ? 64'(-d_sum) : 64'(d_sum);
            state_in     = itvdft_pkg::ST_PIX_DIV;
         end
         itvdft_pkg::ST_PIX_DIV: begin
            if (div_done) begin
               // floor quotient and non-negative remainder
               if (!neg_ff) begin
                  dq_in = div_q;
                  dr_in = div_r;
               end else if (div_r != 29'd0) begin
                  dq_in = ~div_q;
                  dr_in = itvdft_pkg::LIGHT_MPS - div_r;
               end else begin
                  dq_in = 32'(-div_q);
                  dr_in = '0;
               end
               k_in     = '0;
               state_in = itvdft_pkg::ST_CH_RD;
            end
         end
         itvdft_pkg::ST_CH_RD: state_in = itvdft_pkg::ST_CH_M1;
         itvdft_pkg::ST_CH_M1: begin
            f16_in   = {freq_rdata_ff, 4'b0};
            state_in = itvdft_pkg::ST_CH_M2;
         end
         itvdft_pkg::ST_CH_M2: begin
            pa_in    = prod_ff[31:0];
            state_in = itvdft_pkg::ST_CH_M3;
         end
         itvdft_pkg::ST_CH_M3: begin
            div_start    = 1'b1;
            div_dividend = {7'b0, prod_ff[56:0]};
            state_in     = itvdft_pkg::ST_CH_DIV;
         end
         itvdft_pkg::ST_CH_DIV: begin
            if (div_done) begin
               cor_start = 1'b1;
               state_in  = itvdft_pkg::ST_CH_COR;
            end
         end
         itvdft_pkg::ST_CH_COR: begin
            if (cor_done) begin
               state_in = itvdft_pkg::ST_CH_T1;
            end
         end
         itvdft_pkg::ST_CH_T1: begin
            tr_in    = prod_sh30[49:0];
            state_in = itvdft_pkg::ST_CH_T2;
         end
         itvdft_pkg::ST_CH_T2: begin
            // saturating accumulate and write back
            acc_we    = 1'b1;
            acc_wdata = {itvdft_pkg::sat48(50'(base_r) + tr_ff),
                         itvdft_pkg::sat48(50'(base_i) + ti)};
            if (k_next != chans) begin
               k_in     = k_next[5:0];
               state_in = itvdft_pkg::ST_CH_RD;
            end else begin
               // next pixel
               first_in = 1'b0;
               addr_in  = addr_ff + 12'd1;
               k_in     = '0;
               if ((col_ff + 7'd1) == cols) begin
                  col_in = '0;
                  ra_in  = ra_start_ff;
                  if ((row_ff + 7'd1) == rows) begin
                     state_in = itvdft_pkg::ST_OUT_RD;
                  end else begin
                     row_in   = row_ff + 7'd1;
                     dec_in   = dec_ff + dec_step_ff;
                     state_in = itvdft_pkg::ST_PIX_RD;
                  end
               end else begin
                  col_in   = col_ff + 7'd1;
                  ra_in    = ra_ff + ra_step_ff;
                  state_in = itvdft_pkg::ST_PIX_RD;
               end
            end
         end
         itvdft_pkg::ST_OUT_RD: state_in = itvdft_pkg::ST_OUT_EM;
         itvdft_pkg::ST_OUT_EM: begin
            // one result beat per channel
            rsp_valid = 1'b1;
            if (k_next == chans) begin
               state_in = itvdft_pkg::ST_IDLE;
            end else begin
               k_in     = k_next[5:0];
               state_in = itvdft_pkg::ST_OUT_RD;
            end
         end
         default: state_in = itvdft_pkg::ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itvdft_pkg::ST_IDLE;
         k_ff     <= '0;
         addr_ff  <= '0;
         first_ff <= 1'b1;
         nopix_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         addr_ff  <= addr_in;
         first_ff <= first_in;
         nopix_ff <= nopix_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff   <= ra_in;
      dec_ff  <= dec_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      flux_ff <= flux_in;
      r2_ff   <= r2_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      f16_ff  <= f16_in;
      pa_ff   <= pa_in;
      tr_ff   <= tr_in;
   end

   itvdft_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   itvdft_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   itvdft_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .phase   (cor_phase),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

endmodule

>>> sim/image_to_visibility_dft_unit_tb.sv
// ----------------------------------------------------------------------------
// image_to_visibility_dft_unit_tb
// Self-checking bench for the dft visibility unit. Pixel and frequency loads
// are mirrored into local copies of the stores. Each accepted baseline is
// predicted in fixed point (delay, phase, cordic, saturating sums). Every
// result beat is compared field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module image_to_visibility_dft_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // unused operation code, ignored by the unit
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam longint LIGHT = 64'd299792458;
   localparam longint ONE_Q60 = 64'sd1 <<< 60;
   localparam longint ATAN_TURNS [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861};

   logic                clock;
   logic                reset;
   logic                start;
   itvdft_pkg::req_type req_item;
   logic                busy;
   logic                rsp_valid;
   itvdft_pkg::rsp_type rsp_item;
   logic                csr_we;
   logic [2:0]          csr_addr;
   logic [31:0]         csr_wdata;

   // local copy of configuration and stores
   logic [31:0] ra_start_q, ra_step_q, dec_start_q, dec_step_q;
   logic [6:0]  ra_cells_q, dec_cells_q, chan_count_q;
   logic [31:0] pixel_copy [itvdft_pkg::PIX_DEPTH];
   logic [23:0] freq_copy [itvdft_pkg::MAX_CHANNELS];

   itvdft_pkg::rsp_type vis_expected [$];
   int          mismatch_count;
   bit          gaps_on;

   image_to_visibility_dft_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // floor square root of a 64-bit value
   function automatic longint isqrt(input logic [63:0] val);
      logic [63:0] rem, root, bitv;
      rem = val;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(root);
   endfunction

   // phase in turns, floor(delay * f * 16 / c) mod 2^32
   function automatic logic [31:0] phase_turns(input longint delay, input logic [23:0] f);
      logic signed [127:0] prod, quo;
      prod = delay;
      prod = prod * $signed({1'b0, f, 4'b0000});
      quo = prod / $signed(128'(LIGHT));
      if (prod < 0 && quo * $signed(128'(LIGHT)) != prod) quo = quo - 1;
      return quo[31:0];
   endfunction

   // cordic cosine and sine, q1.30
   task automatic cordic_cos_sin(input logic [31:0] ph, output longint cs, output longint sn);
      longint x, y, z, xs, ys;
      x = 652032874;
      y = 0;
      z = longint'(ph[29:0]);
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
         end
      end
      case (ph[31:30])
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endtask

   function automatic longint clip48(input longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
   endfunction

   // predicted visibilities of one baseline
   task automatic predict_visibilities(input itvdft_pkg::req_type item);
      longint acc_re [itvdft_pkg::MAX_CHANNELS];
      longint acc_im [itvdft_pkg::MAX_CHANNELS];
      int cols, rows, chans;
      logic [31:0] ra_w, dec_w;
      longint ra, dec, nn, delay, flux, cs, sn, u, v, w;
      logic [63:0] r2;
      itvdft_pkg::rsp_type beat;
      cols = (ra_cells_q > itvdft_pkg::MAX_RA_CELLS) ? itvdft_pkg::MAX_RA_CELLS
                                                      : ra_cells_q;
      rows = (dec_cells_q > itvdft_pkg::MAX_DEC_CELLS) ? itvdft_pkg::MAX_DEC_CELLS
                                                        : dec_cells_q;
      chans = (chan_count_q > itvdft_pkg::MAX_CHANNELS) ? itvdft_pkg::MAX_CHANNELS
                                                         : chan_count_q;
      u = item.u_mm;
      v = item.v_mm;
      w = item.w_mm;
      for (int k = 0; k < itvdft_pkg::MAX_CHANNELS; k++) begin
         acc_re[k] = 0;
         acc_im[k] = 0;
      end
      for (int m = 0; m < rows; m++) begin
         dec_w = dec_start_q + 32'(m) * dec_step_q;
         dec = $signed(dec_w);
         for (int l = 0; l < cols; l++) begin
            ra_w = ra_start_q + 32'(l) * ra_step_q;
            ra = $signed(ra_w);
            r2 = 64'(ra * ra) + 64'(dec * dec);
            nn = (r2 >= 64'(ONE_Q60)) ? 0 : isqrt(64'(ONE_Q60) - r2);
            delay = ((ra * u) >>> 2) + ((dec * v) >>> 2) + ((nn * w) >>> 2);
            flux = $signed(pixel_copy[m * cols + l]);
            for (int k = 0; k < chans; k++) begin
               cordic_cos_sin(phase_turns(delay, freq_copy[k]), cs, sn);
               acc_re[k] = clip48(acc_re[k] + ((flux * cs) >>> 30));
               acc_im[k] = clip48(acc_im[k] + ((flux * sn) >>> 30));
            end
         end
      end
      for (int k = 0; k < chans; k++) begin
         beat.channel = 6'(k);
         beat.vis_real = acc_re[k][47:0];
         beat.vis_imag = acc_im[k][47:0];
         beat.last = (k + 1 == chans);
         vis_expected.push_back(beat);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      itvdft_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (vis_expected.size() == 0) begin
            report_mismatch("unexpected beat", 48'(rsp_item.channel), 48'd0);
         end else begin
            want = vis_expected.pop_front();
            if (rsp_item.channel !== want.channel)
               report_mismatch("channel", 48'(rsp_item.channel), 48'(want.channel));
            if (rsp_item.vis_real !== want.vis_real)
               report_mismatch("vis_real", rsp_item.vis_real, want.vis_real);
            if (rsp_item.vis_imag !== want.vis_imag)
               report_mismatch("vis_imag", rsp_item.vis_imag, want.vis_imag);
            if (rsp_item.last !== want.last)
               report_mismatch("last", 48'(rsp_item.last), 48'(want.last));
         end
      end
   end

   // random idle burst before a beat, entered and left at the falling edge
   task automatic maybe_gap();
      if (gaps_on && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) @(negedge clock);
   endtask

   // send one request beat; called and returns at a falling edge
   task automatic send_beat(input itvdft_pkg::req_type item);
      maybe_gap();
      req_item = item;
      start = 1'b1;
      do @(posedge clock); while (busy);
      if (item.operation == itvdft_pkg::OP_LOAD_PIXEL) begin
         pixel_copy[item.index] = item.flux;
      end else if (item.operation == itvdft_pkg::OP_LOAD_FREQ) begin
         if (item.index < itvdft_pkg::MAX_CHANNELS) freq_copy[item.index[5:0]] = item.freq_khz;
      end else if (item.operation == itvdft_pkg::OP_BASELINE) begin
         predict_visibilities(item);
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_pixel(input int idx, input logic [31:0] flux);
      itvdft_pkg::req_type item;
      item = '0;
      item.operation = itvdft_pkg::OP_LOAD_PIXEL;
      item.index = 12'(idx);
      item.flux = flux;
      item.u_mm = $urandom();
      send_beat(item);
   endtask

   task automatic send_freq(input int idx, input logic [23:0] f);
      itvdft_pkg::req_type item;
      item = '0;
      item.operation = itvdft_pkg::OP_LOAD_FREQ;
      item.index = 12'(idx);
      item.freq_khz = f;
      send_beat(item);
   endtask

   task automatic send_baseline(input logic [31:0] u, input logic [31:0] v,
                                input logic [31:0] w);
      itvdft_pkg::req_type item;
      item = '0;
      item.operation = itvdft_pkg::OP_BASELINE;
      item.index = 12'($urandom());
      item.flux = $urandom();
      item.freq_khz = 24'($urandom());
      item.u_mm = u;
      item.v_mm = v;
      item.w_mm = w;
      send_beat(item);
   endtask

   // wait until all beats are in and the unit is idle
   task automatic drain();
      while (vis_expected.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input itvdft_pkg::csr_index_type idx, input logic [31:0] data);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         itvdft_pkg::CSR_RA_START:   ra_start_q = data;
         itvdft_pkg::CSR_RA_STEP:    ra_step_q = data;
         itvdft_pkg::CSR_RA_CELLS:   ra_cells_q = data[6:0];
         itvdft_pkg::CSR_DEC_START:  dec_start_q = data;
         itvdft_pkg::CSR_DEC_STEP:   dec_step_q = data;
         itvdft_pkg::CSR_DEC_CELLS:  dec_cells_q = data[6:0];
         default:                    chan_count_q = data[6:0];
      endcase
   endtask

   task automatic set_image(input logic [31:0] ra0, input logic [31:0] dra,
                            input logic [31:0] cols, input logic [31:0] dec0,
                            input logic [31:0] ddec, input logic [31:0] rows,
                            input logic [31:0] chans);
      drain();
      write_csr(itvdft_pkg::CSR_RA_START, ra0);
      write_csr(itvdft_pkg::CSR_RA_STEP, dra);
      write_csr(itvdft_pkg::CSR_RA_CELLS, cols);
      write_csr(itvdft_pkg::CSR_DEC_START, dec0);
      write_csr(itvdft_pkg::CSR_DEC_STEP, ddec);
      write_csr(itvdft_pkg::CSR_DEC_CELLS, rows);
      write_csr(itvdft_pkg::CSR_CHAN_COUNT, chans);
   endtask

   // direction cosine mostly inside the unit circle
   function automatic logic [31:0] rand_cosine();
      if ($urandom_range(0, 4) == 0) return $urandom();
      return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
   endfunction

   // fill the first 64 pixel entries and every frequency entry, then edge values
   task automatic test_loads();
      for (int i = 0; i < 64; i++) send_pixel(i, $urandom());
      for (int i = 0; i < 64; i++) send_freq(i, 24'($urandom()));
      send_pixel(0, 32'h7fff_ffff);
      send_pixel(1, 32'h8000_0000);
      send_pixel(4095, 32'h7fff_ffff);
      send_freq(0, 24'hff_ffff);
      send_freq(1, 24'h00_0000);
      send_freq(64, 24'h12_3456);
      send_freq(4095, 24'hab_cdef);
   endtask

   task automatic test_corner_baselines();
      itvdft_pkg::req_type item;
      set_image(32'h0, 32'h0, 1, 32'h0, 32'h0, 1, 2);
      send_baseline(32'h0, 32'h0, 32'h0);
      send_baseline(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_baseline(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      item = '0;
      item.operation = OP_UNUSED;
      item.index = 12'hfff;
      send_beat(item);
      // below the horizon and extreme cosines
      set_image(32'h7fff_ffff, 32'h8000_0000, 2, 32'h8000_0000, 32'h7fff_ffff, 2, 3);
      send_baseline($urandom(), $urandom(), $urandom());
      set_image(32'h4000_0000, 32'h0, 1, 32'h0, 32'h0, 1, 1);
      send_baseline(32'h1234_5678, 32'hedcb_a987, 32'h7fff_ffff);
      // channel count above its limit, then none
      set_image(32'h0100_0000, 32'h0, 1, 32'hff00_0000, 32'h0, 1, 127);
      send_baseline($urandom(), $urandom(), $urandom());
      set_image(32'h0, 32'h0, 1, 32'h0, 32'h0, 1, 0);
      send_baseline($urandom(), $urandom(), $urandom());
      // widest row, tallest column, empty image
      set_image(32'he000_0000, 32'h0100_0000, 127, 32'h0, 32'h0, 1, 1);
      send_baseline($urandom(), $urandom(), $urandom());
      set_image(32'h0, 32'h0, 1, 32'h2000_0000, 32'hff00_0000, 64, 2);
      send_baseline($urandom(), $urandom(), $urandom());
      set_image(32'h0, 32'h0, 0, 32'h0, 32'h0, 3, 2);
      send_baseline($urandom(), $urandom(), $urandom());
   endtask

   task automatic test_random_traffic();
      int cols, rows;
      for (int n = 0; n < 16; n++) begin
         if (n >= 12) gaps_on = 1'b0;
         if (n % 4 == 0) begin
            cols = $urandom_range(1, 4);
            rows = $urandom_range(1, 4);
            set_image(rand_cosine(), 32'($signed($urandom_range(0, 32'h0800_0000))
                      - 32'sh0400_0000), cols, rand_cosine(),
                      32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000),
                      rows, $urandom_range(1, 8));
         end
         case ($urandom_range(0, 5))
            0: send_pixel($urandom_range(0, 63), $urandom());
            1: send_freq($urandom_range(0, 127), 24'($urandom()));
            default: send_baseline($urandom(), $urandom(), $urandom());
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      gaps_on = 1'b1;
      ra_start_q = 0; ra_step_q = 0; ra_cells_q = 64;
      dec_start_q = 0; dec_step_q = 0; dec_cells_q = 64;
      chan_count_q = 64;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_loads();
      test_corner_baselines();
      test_random_traffic();
      drain();
      repeat (50) @(negedge clock);
      if (mismatch_count == 0 && vis_expected.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
